@@ src/joystick_midi_event_mapper_assert.svh @@
// Assertion macros for the joystick to MIDI event mapper.
`ifndef JOYSTICK_MIDI_EVENT_MAPPER_ASSERT_SVH
`define JOYSTICK_MIDI_EVENT_MAPPER_ASSERT_SVH
`ifndef SYNTH
// Implication checked in the same cycle.
`define JMEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joystick mapper: same-cycle check failed");
// Implication checked in the cycle after the antecedent.
`define JMEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joystick mapper: next-cycle check failed");
`else
`define JMEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define JMEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/jmem_pkg.sv @@
// Types, codes and constants shared by the joystick to MIDI event mapper.
package jmem_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic       operation;
        logic [7:0] sample_vertical;
        logic [7:0] sample_horizontal;
        logic [3:0] packet_length;
        logic [7:0] packet_byte0;
        logic [7:0] packet_byte1;
        logic [7:0] packet_byte2;
        logic [7:0] packet_byte3;
    } t_mid_in;

    typedef struct packed {
        logic [7:0] out_header;
        logic [7:0] out_status;
        logic [7:0] out_arg_one;
        logic [7:0] out_arg_two;
    } t_mid_out;

    // Byte enable bit 3 is the header byte, bit 0 the second data byte.
    typedef struct packed {
        logic       en;
        logic [3:0] be;
        t_word      data;
    } t_store_wr;

    typedef struct packed {
        logic       en;
        logic [2:0] addr;
        t_word      data;
    } t_table_wr;

    localparam logic       CFG_LOW_THRESHOLD  = 1'b0;
    localparam logic       CFG_HIGH_THRESHOLD = 1'b1;
    localparam logic [7:0] RESET_LOW          = 8'd32;
    localparam logic [7:0] RESET_HIGH         = 8'd224;

    localparam logic       OP_SAMPLE = 1'b0;
    localparam logic       OP_PACKET = 1'b1;

    localparam logic [2:0] POS_CENTRE = 3'd0;
    localparam logic [2:0] POS_UP     = 3'd1;
    localparam logic [2:0] POS_DOWN   = 3'd2;
    localparam logic [2:0] POS_LEFT   = 3'd3;
    localparam logic [2:0] POS_RIGHT  = 3'd4;

    localparam logic [2:0] MOVE_PRESS_UP = 3'd0;

    localparam logic [3:0] PACKET_LEN      = 4'd4;
    localparam logic [7:0] HDR_PROGRAM     = 8'h0C;
    localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
    localparam logic [7:0] HDR_CONTROL     = 8'h0B;
    localparam logic [7:0] STATUS_CONTROL  = 8'hB0;

    localparam logic [7:0] CC_MODE         = 8'd15;
    localparam logic [7:0] CC_HEAD_FIRST   = 8'd16;
    localparam logic [7:0] CC_HEAD_LAST    = 8'd23;
    localparam logic [7:0] CC_ARG1_FIRST   = 8'd24;
    localparam logic [7:0] CC_ARG1_LAST    = 8'd31;
    localparam logic [7:0] CC_ARG2_FIRST   = 8'd32;
    localparam logic [7:0] CC_ARG2_LAST    = 8'd39;
    localparam logic [7:0] CC_POINTER      = 8'd40;
    localparam logic [7:0] CC_SLOT_HEAD    = 8'd41;
    localparam logic [7:0] CC_SLOT_ARG1    = 8'd42;
    localparam logic [7:0] CC_SLOT_ARG2    = 8'd43;

    localparam t_word ENTRY0_RESET = 32'h0990_2A2A;

    // Value of a direction table entry that has not been written since reset.
    function automatic t_word table_reset_value(input logic [2:0] entry);
        t_word v;
        v = (entry == 3'd0) ? ENTRY0_RESET : '0;
        return v;
    endfunction

endpackage

@@ src/jmem_table.sv @@
// Direction table: eight 4-byte entries in a synchronous memory with reset tracking.
module jmem_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_raddr,
    input  jmem_pkg::t_table_wr i_wr,
    output jmem_pkg::t_word     o_rdata
);
    import jmem_pkg::*;

    t_word      r_mem [8];
    logic [7:0] r_valid;
    t_word      r_rdata;
    logic [2:0] r_raddr;
    logic       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata  <= r_mem[i_raddr];
        r_raddr  <= i_raddr;
        r_rvalid <= r_valid[i_raddr];
    end

    // An entry never written since reset reads as its reset contents.
    assign o_rdata = r_rvalid ? r_rdata : table_reset_value(r_raddr);

endmodule

@@ src/jmem_store.sv @@
// Preset store: synchronous word memory with byte enables and a clearing pass after reset.
module jmem_store #(
    parameter int ROWS  = 128,
    parameter int ROW_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ROW_W-1:0]    i_raddr,
    input  logic [ROW_W-1:0]    i_waddr,
    input  jmem_pkg::t_store_wr i_wr,
    output jmem_pkg::t_word     o_rdata,
    output logic                o_busy
);
    import jmem_pkg::*;

    t_word            r_mem [ROWS];
    t_word            r_rdata;
    logic             r_busy;
    logic [ROW_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + ROW_W'(1);
            if (r_clr_addr == ROW_W'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            for (int k = 0; k < 4; k++) begin
                if (i_wr.be[k]) begin
                    r_mem[i_waddr][k*8 +: 8] <= i_wr.data[k*8 +: 8];
                end
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

@@ src/joystick_midi_event_mapper.sv @@
// Joystick to USB-MIDI event mapper: top level with the item sequencer.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries either a
// joystick sample or a 4-byte USB-MIDI packet. Output channel (o_out_valid /
// i_out_ready, payload o_out) carries the USB-MIDI packets that are sent.
// Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// A sample that sends a table entry goes through S_TREAD (one table memory
// read) and S_EMIT to the output register, a program change through S_EMIT
// alone. Table edits read, modify and write back the entry (S_TRMW); other
// packets are handled in S_IDLE. A preset load copies 8 words from the preset
// store to the table, one word a cycle, through the single store read port.
// After reset all PRESET_COUNT*8 preset store words are cleared, one word a
// cycle, while no item is accepted; the table restores its reset contents
// at once. The result sits in an output register: a new item is accepted
// while it waits, but a second result waits until the receiver takes the
// first one, and no further item is accepted meanwhile.
module joystick_midi_event_mapper #(
    parameter int PRESET_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jmem_pkg::t_mid_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jmem_pkg::t_mid_out o_out
);
    import jmem_pkg::*;

    `include "joystick_midi_event_mapper_assert.svh"

    localparam int STORE_ROWS = PRESET_COUNT * 8;
    localparam int ROW_W      = $clog2(STORE_ROWS);

    localparam logic [1:0] EDIT_HEAD = 2'd0;
    localparam logic [1:0] EDIT_ARG1 = 2'd1;
    localparam logic [1:0] EDIT_ARG2 = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREAD,
        S_TRMW,
        S_LOAD,
        S_EMIT
    } t_state;

    t_state     r_state,  n_state;
    logic [7:0] r_low,    n_low;
    logic [7:0] r_high,   n_high;
    logic [2:0] r_prev,   n_prev;
    logic       r_mode,   n_mode;
    logic [6:0] r_pn,     n_pn;
    logic [6:0] r_sp,     n_sp;
    logic [3:0] r_step,   n_step;
    logic [3:0] r_preset, n_preset;
    logic [2:0] r_entry,  n_entry;
    logic [1:0] r_edit,   n_edit;
    logic [7:0] r_cfg,    n_cfg;
    logic       r_out_valid, n_out_valid;
    t_mid_out   r_pend,   n_pend;
    t_mid_out   r_out,    n_out;

    logic             in_acc;
    logic             store_busy;
    logic [2:0]       pos;
    logic [2:0]       move;
    logic             pkt_ok;
    logic             is_ctrl;
    logic [7:0]       b2;
    logic [7:0]       b3;
    logic [7:0]       type_b;
    logic [7:0]       hdr_b;
    logic             hdr_off;
    logic             slot_ok;
    logic [2:0]       tbl_raddr;
    t_word            tbl_rdata;
    t_table_wr        tbl_wr;
    t_word            tbl_mod;
    logic [ROW_W-1:0] st_raddr;
    logic [ROW_W-1:0] st_waddr;
    t_store_wr        st_wr;
    t_word            st_rdata;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !store_busy;

    // Vertical axis first, then horizontal.
    always_comb begin
        if (i_in.sample_vertical < r_low) begin
            pos = POS_UP;
        end else if (i_in.sample_vertical > r_high) begin
            pos = POS_DOWN;
        end else if (i_in.sample_horizontal < r_low) begin
            pos = POS_LEFT;
        end else if (i_in.sample_horizontal > r_high) begin
            pos = POS_RIGHT;
        end else begin
            pos = POS_CENTRE;
        end
    end

    // Leaving a direction is a release (4..7), leaving centre a press (0..3).
    assign move = (r_prev != POS_CENTRE) ? 3'(r_prev + 3'd3) : 3'(pos - 3'd1);

    assign b2      = i_in.packet_byte2;
    assign b3      = i_in.packet_byte3;
    assign type_b  = b3 | 8'h80;
    assign hdr_b   = {4'h0, type_b[7:4]};
    assign hdr_off = (hdr_b == 8'h0F);
    assign pkt_ok  = (i_in.packet_length == PACKET_LEN);
    assign is_ctrl = pkt_ok && (i_in.packet_byte0 == HDR_CONTROL)
                     && (i_in.packet_byte1 == STATUS_CONTROL);
    assign slot_ok = {1'b0, r_sp} < 8'(STORE_ROWS);

    assign tbl_raddr = (i_in.operation == OP_SAMPLE) ? move : b2[2:0];

    // Direct store writes for the slot controllers.
    always_comb begin
        st_wr      = '0;
        st_waddr   = ROW_W'(r_sp);
        if (in_acc && (i_in.operation == OP_PACKET) && is_ctrl && slot_ok) begin
            if (b2 == CC_SLOT_HEAD) begin
                st_wr.en = 1'b1;
                if (hdr_off) begin
                    st_wr.be = 4'b1000;
                end else begin
                    st_wr.be   = 4'b1100;
                    st_wr.data = {hdr_b, type_b, 16'h0000};
                end
            end else if (b2 == CC_SLOT_ARG1) begin
                st_wr.en   = 1'b1;
                st_wr.be   = 4'b0010;
                st_wr.data = {16'h0000, b3, 8'h00};
            end else if (b2 == CC_SLOT_ARG2) begin
                st_wr.en   = 1'b1;
                st_wr.be   = 4'b0001;
                st_wr.data = {24'h000000, b3};
            end
        end
    end

    assign st_raddr = ROW_W'({r_preset, r_step[2:0]});

    // Read-modify-write of one table entry: header and status bytes, or one data byte.
    always_comb begin
        tbl_mod = tbl_rdata;
        case (r_edit)
            EDIT_HEAD: begin
                if (r_cfg[6:4] == 3'b111) begin
                    tbl_mod[31:24] = 8'h00;
                end else begin
                    tbl_mod[31:24] = {5'b00001, r_cfg[6:4]};
                    tbl_mod[23:16] = r_cfg | 8'h80;
                end
            end
            EDIT_ARG1: tbl_mod[15:8] = r_cfg;
            EDIT_ARG2: tbl_mod[7:0]  = r_cfg;
            default:   tbl_mod = tbl_rdata;
        endcase
    end

    always_comb begin
        tbl_wr = '0;
        if (r_state == S_TRMW) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = r_entry;
            tbl_wr.data = tbl_mod;
        end else if ((r_state == S_LOAD) && (r_step != 4'd0)) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = 3'(r_step - 4'd1);
            tbl_wr.data = st_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_prev      = r_prev;
        n_mode      = r_mode;
        n_pn        = r_pn;
        n_sp        = r_sp;
        n_step      = r_step;
        n_preset    = r_preset;
        n_entry     = r_entry;
        n_edit      = r_edit;
        n_cfg       = r_cfg;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LOW_THRESHOLD) begin
                n_low = i_cfg_data;
            end else begin
                n_high = i_cfg_data;
            end
        end

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.operation == OP_SAMPLE) begin
                        if (pos != r_prev) begin
                            n_prev = pos;
                            if (!r_mode || move[1]) begin
                                n_state = S_TREAD;
                            end else if (!move[2]) begin
                                n_pn = (move == MOVE_PRESS_UP) ? 7'(r_pn + 7'd1)
                                                               : 7'(r_pn - 7'd1);
                                n_pend  = '{HDR_PROGRAM, STATUS_PROGRAM,
                                            {1'b0, n_pn}, 8'h00};
                                n_state = S_EMIT;
                            end
                        end
                    end else if (pkt_ok && (i_in.packet_byte0 == HDR_PROGRAM)
                                 && (i_in.packet_byte1 == STATUS_PROGRAM)) begin
                        if ({1'b0, b3[3:0]} < 5'(PRESET_COUNT)) begin
                            n_preset = b3[3:0];
                            n_step   = '0;
                            n_state  = S_LOAD;
                        end
                    end else if (is_ctrl) begin
                        n_entry = b2[2:0];
                        n_cfg   = b3;
                        if (b2 == CC_MODE) begin
                            n_mode = !r_mode;
                        end else if (b2 >= CC_HEAD_FIRST && b2 <= CC_HEAD_LAST) begin
                            n_edit  = EDIT_HEAD;
                            n_state = S_TRMW;
                        end else if (b2 >= CC_ARG1_FIRST && b2 <= CC_ARG1_LAST) begin
                            n_edit  = EDIT_ARG1;
                            n_state = S_TRMW;
                        end else if (b2 >= CC_ARG2_FIRST && b2 <= CC_ARG2_LAST) begin
                            n_edit  = EDIT_ARG2;
                            n_state = S_TRMW;
                        end else if (b2 == CC_POINTER) begin
                            n_sp = b3[6:0];
                        end
                    end
                end
            end
            S_TREAD: begin
                // An entry with a zero header byte is not sent.
                if (tbl_rdata[31:24] == 8'h00) begin
                    n_state = S_IDLE;
                end else begin
                    n_pend  = t_mid_out'(tbl_rdata);
                    n_state = S_EMIT;
                end
            end
            S_TRMW: begin
                n_state = S_IDLE;
            end
            S_LOAD: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd8) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= RESET_LOW;
            r_high      <= RESET_HIGH;
            r_prev      <= POS_CENTRE;
            r_mode      <= 1'b0;
            r_pn        <= '0;
            r_sp        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_high      <= n_high;
            r_prev      <= n_prev;
            r_mode      <= n_mode;
            r_pn        <= n_pn;
            r_sp        <= n_sp;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_preset <= n_preset;
        r_entry  <= n_entry;
        r_edit   <= n_edit;
        r_cfg    <= n_cfg;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    jmem_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (tbl_raddr),
        .i_wr    (tbl_wr),
        .o_rdata (tbl_rdata)
    );

    jmem_store #(
        .ROWS  (STORE_ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (st_raddr),
        .i_waddr (st_waddr),
        .i_wr    (st_wr),
        .o_rdata (st_rdata),
        .o_busy  (store_busy)
    );

    `JMEM_ASSERT_NOW(a_sent_header_nonzero, i_clk, i_rst_n, o_out_valid, o_out.out_header != 8'h00)
    `JMEM_ASSERT_NOW(a_no_table_write_in_clear, i_clk, i_rst_n, store_busy, !tbl_wr.en)
    `JMEM_ASSERT_NEXT(a_accept_not_while_busy, i_clk, i_rst_n, (r_state == S_LOAD) && (r_step == 4'd8), o_in_ready || store_busy || (r_state == S_IDLE))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the joystick to USB-MIDI event mapper.
module tb_top;
    import jmem_pkg::*;

    localparam int PRESET_COUNT   = 16;
    localparam int STORE_BYTES    = PRESET_COUNT * 32;
    localparam int MAX_IDLE       = 6;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 115;
    localparam int PHASE_COUNT    = 9;
    localparam logic [3:0] HDR_CLEAR = 4'hF;
    localparam logic [7:0] KIND_BIT  = 8'h80;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_idx   = CFG_LOW_THRESHOLD;
    logic [7:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_mid_in    i_in        = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    t_mid_out   o_out;

    // Mirror of the mapper state.
    logic [7:0] thr_low  = RESET_LOW;
    logic [7:0] thr_high = RESET_HIGH;
    logic [7:0] entry_bytes [0:31];
    logic [7:0] preset_bytes [0:STORE_BYTES-1];
    logic [2:0] prev_pos     = POS_CENTRE;
    logic       prog_mode_on = 1'b0;
    logic [6:0] prog_num     = '0;
    logic [6:0] slot_ptr     = '0;

    t_mid_in  queued_events [$];
    t_mid_out midi_expected [$];

    bit steady_flow    = 1'b0;
    int send_gap       = 0;
    int hold_cnt       = 0;
    int quiet_cycles   = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int mismatches     = 0;
    int settings_used  = 1;

    joystick_midi_event_mapper #(.PRESET_COUNT(PRESET_COUNT)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void write_preset_byte(input int addr, input logic [7:0] v);
        if (addr < STORE_BYTES) preset_bytes[addr] = v;
    endfunction

    // Updates the mirror for one accepted item and queues the MIDI packet it sends.
    task automatic map_joystick_item(input t_mid_in it);
        logic [2:0] pos, move, e;
        logic [7:0] val, kind, cc;
        int         slot;
        t_mid_out   r;
        val  = it.packet_byte3;
        kind = val | KIND_BIT;
        cc   = it.packet_byte2;
        slot = int'(slot_ptr) * 4;
        if (it.operation == OP_PACKET) begin
            if (it.packet_length == PACKET_LEN) begin
                if (it.packet_byte0 == HDR_PROGRAM && it.packet_byte1 == STATUS_PROGRAM) begin
                    if (int'(val[3:0]) < PRESET_COUNT)
                        for (int i = 0; i < 32; i++)
                            entry_bytes[i] = preset_bytes[int'(val[3:0]) * 32 + i];
                end else if (it.packet_byte0 == HDR_CONTROL &&
                             it.packet_byte1 == STATUS_CONTROL) begin
                    if (cc == CC_MODE) begin
                        prog_mode_on = !prog_mode_on;
                    end else if (cc >= CC_HEAD_FIRST && cc <= CC_HEAD_LAST) begin
                        e = 3'(cc - CC_HEAD_FIRST);
                        if (kind[7:4] == HDR_CLEAR) begin
                            entry_bytes[{e, 2'd0}] = '0;
                        end else begin
                            entry_bytes[{e, 2'd0}] = {4'h0, kind[7:4]};
                            entry_bytes[{e, 2'd1}] = kind;
                        end
                    end else if (cc >= CC_ARG1_FIRST && cc <= CC_ARG1_LAST) begin
                        e = 3'(cc - CC_ARG1_FIRST);
                        entry_bytes[{e, 2'd2}] = val;
                    end else if (cc >= CC_ARG2_FIRST && cc <= CC_ARG2_LAST) begin
                        e = 3'(cc - CC_ARG2_FIRST);
                        entry_bytes[{e, 2'd3}] = val;
                    end else if (cc == CC_POINTER) begin
                        slot_ptr = val[6:0];
                    end else if (cc == CC_SLOT_HEAD) begin
                        if (kind[7:4] == HDR_CLEAR) begin
                            write_preset_byte(slot, '0);
                        end else begin
                            write_preset_byte(slot, {4'h0, kind[7:4]});
                            write_preset_byte(slot + 1, kind);
                        end
                    end else if (cc == CC_SLOT_ARG1) begin
                        write_preset_byte(slot + 2, val);
                    end else if (cc == CC_SLOT_ARG2) begin
                        write_preset_byte(slot + 3, val);
                    end
                end
            end
        end else begin
            if (it.sample_vertical < thr_low)         pos = POS_UP;
            else if (it.sample_vertical > thr_high)   pos = POS_DOWN;
            else if (it.sample_horizontal < thr_low)  pos = POS_LEFT;
            else if (it.sample_horizontal > thr_high) pos = POS_RIGHT;
            else                                      pos = POS_CENTRE;
            if (pos != prev_pos) begin
                // Leaving a direction always gives its release, even on a direct swap.
                move = (prev_pos != POS_CENTRE) ? 3'(prev_pos + 3'd3) : 3'(pos - 3'd1);
                prev_pos = pos;
                // Bit 1 of the move marks left or right, bit 2 a release.
                if (!prog_mode_on || move[1]) begin
                    if (entry_bytes[{move, 2'd0}] != '0) begin
                        r = '{entry_bytes[{move, 2'd0}], entry_bytes[{move, 2'd1}],
                              entry_bytes[{move, 2'd2}], entry_bytes[{move, 2'd3}]};
                        midi_expected.push_back(r);
                    end
                end else if (!move[2]) begin
                    prog_num = (move == MOVE_PRESS_UP) ? prog_num + 7'd1 : prog_num - 7'd1;
                    r = '{HDR_PROGRAM, STATUS_PROGRAM, {1'b0, prog_num}, 8'h00};
                    midi_expected.push_back(r);
                end
            end
        end
    endtask

    function automatic t_mid_in noise_item();
        logic [63:0] raw;
        t_mid_in     it;
        raw = {$urandom, $urandom};
        it  = raw[$bits(t_mid_in)-1:0];
        return it;
    endfunction

    function automatic t_mid_in sample_item(input logic [7:0] v, input logic [7:0] h);
        t_mid_in it;
        it = noise_item();
        it.operation         = OP_SAMPLE;
        it.sample_vertical   = v;
        it.sample_horizontal = h;
        return it;
    endfunction

    function automatic t_mid_in packet_item(input logic [3:0] len, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3);
        t_mid_in it;
        it = noise_item();
        it.operation     = OP_PACKET;
        it.packet_length = len;
        it.packet_byte0  = b0;
        it.packet_byte1  = b1;
        it.packet_byte2  = b2;
        it.packet_byte3  = b3;
        return it;
    endfunction

    function automatic t_mid_in control_item(input logic [7:0] cc, input logic [7:0] val);
        return packet_item(PACKET_LEN, HDR_CONTROL, STATUS_CONTROL, cc, val);
    endfunction

    // Readings cluster around the thresholds so that positions change often.
    function automatic logic [7:0] pick_reading();
        int sel, v;
        sel = $urandom_range(0, 9);
        if (sel < 3)       v = int'(thr_low) + int'($urandom_range(0, 3)) - 2;
        else if (sel < 6)  v = int'(thr_high) + int'($urandom_range(0, 3)) - 1;
        else if (sel == 6) v = ($urandom_range(0, 1) != 0) ? 255 : 0;
        else               v = $urandom_range(0, 255);
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic t_mid_in random_item();
        int         sel;
        logic [7:0] b0, b1, cc;
        logic [3:0] len;
        if ($urandom_range(0, 9) < 6) return sample_item(pick_reading(), pick_reading());
        len = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15)) : PACKET_LEN;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            b0 = HDR_CONTROL;
            b1 = STATUS_CONTROL;
        end else if (sel < 17) begin
            b0 = HDR_PROGRAM;
            b1 = STATUS_PROGRAM;
        end else if (sel == 17) begin
            b0 = HDR_CONTROL;
            b1 = 8'($urandom);
        end else begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
        end
        cc = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                         : 8'($urandom_range(CC_MODE, CC_SLOT_ARG2));
        return packet_item(len, b0, b1, cc, 8'($urandom));
    endfunction

    function automatic void check_byte(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_threshold(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LOW_THRESHOLD) thr_low = val;
        else                          thr_high = val;
    endtask

    // Packets give no result, so a preset load may still be running once the
    // queue is empty; the settle pause covers it.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (queued_events.size() != 0 || i_in_valid || midi_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_events
        int gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && o_in_ready) begin
            gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap == 0 && queued_events.size() != 0) begin
                i_in <= queued_events.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                send_gap   <= gap;
            end
        end else if (!i_in_valid) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (queued_events.size() != 0) begin
                i_in       <= queued_events.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            hold_cnt    <= 0;
        end else if (o_out_valid && i_out_ready) begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                hold_cnt    <= stall;
            end
        end else if (!i_out_ready) begin
            if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
            else              i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_mid_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (midi_expected.size() == 0) begin
                    $display("%0t: packet expected none, got %h", $time, o_out);
                    mismatches++;
                end else begin
                    want = midi_expected.pop_front();
                    check_byte("out_header", want.out_header, o_out.out_header);
                    check_byte("out_status", want.out_status, o_out.out_status);
                    check_byte("out_arg_one", want.out_arg_one, o_out.out_arg_one);
                    check_byte("out_arg_two", want.out_arg_two, o_out.out_arg_two);
                end
            end
            if (i_in_valid && o_in_ready) begin
                items_accepted++;
                map_joystick_item(i_in);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : run_test
        logic [7:0] lo, hi;
        for (int i = 0; i < 32; i++) entry_bytes[i] = '0;
        {entry_bytes[0], entry_bytes[1], entry_bytes[2], entry_bytes[3]} = ENTRY0_RESET;
        for (int i = 0; i < STORE_BYTES; i++) preset_bytes[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run with the reset thresholds.
        queued_events.push_back(packet_item(4'd8, HDR_CONTROL, STATUS_CONTROL, CC_MODE, 8'h00));
        queued_events.push_back(packet_item(4'd0, HDR_CONTROL, STATUS_CONTROL, CC_MODE, 8'h00));
        queued_events.push_back(control_item(CC_HEAD_FIRST + 8'd1, 8'h25));
        queued_events.push_back(control_item(CC_ARG1_FIRST + 8'd1, 8'h00));
        queued_events.push_back(control_item(CC_ARG2_FIRST + 8'd1, 8'hFF));
        queued_events.push_back(control_item(CC_HEAD_LAST - 8'd3, 8'h10));
        queued_events.push_back(sample_item(8'd128, 8'd128));
        queued_events.push_back(sample_item(8'd31, 8'd128));
        queued_events.push_back(sample_item(8'd32, 8'd224));
        queued_events.push_back(sample_item(8'd225, 8'd0));
        queued_events.push_back(sample_item(8'd0, 8'd255));
        queued_events.push_back(control_item(CC_MODE, 8'h00));
        queued_events.push_back(sample_item(8'd128, 8'd128));
        // A down press from program zero wraps round to the top.
        queued_events.push_back(sample_item(8'd255, 8'd255));
        queued_events.push_back(sample_item(8'd128, 8'd128));
        queued_events.push_back(sample_item(8'd0, 8'd0));
        queued_events.push_back(sample_item(8'd128, 8'd31));
        queued_events.push_back(control_item(CC_MODE, 8'hFF));
        queued_events.push_back(control_item(CC_POINTER, 8'h85));
        queued_events.push_back(control_item(CC_SLOT_HEAD, 8'h33));
        queued_events.push_back(control_item(CC_SLOT_ARG1, 8'h44));
        queued_events.push_back(control_item(CC_SLOT_ARG2, 8'h55));
        queued_events.push_back(packet_item(PACKET_LEN, HDR_PROGRAM, STATUS_PROGRAM,
                                            8'h00, 8'hF0));
        queued_events.push_back(sample_item(8'd250, 8'd128));
        queued_events.push_back(sample_item(8'd128, 8'd128));
        queued_events.push_back(control_item(CC_POINTER, 8'h7F));
        queued_events.push_back(control_item(CC_SLOT_HEAD, 8'hF5));
        queued_events.push_back(packet_item(PACKET_LEN, HDR_PROGRAM, STATUS_PROGRAM,
                                            8'h00, 8'h0F));
        queued_events.push_back(control_item(CC_HEAD_FIRST, 8'h7F));
        queued_events.push_back(packet_item(PACKET_LEN, HDR_PROGRAM, STATUS_CONTROL,
                                            CC_MODE, 8'h00));
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin lo = 8'd0;   hi = 8'd255; end
                1: begin lo = 8'd255; hi = 8'd0;   end
                2: begin lo = 8'd0;   hi = 8'd0;   end
                3: begin lo = 8'd1;   hi = 8'd254; end
                4: begin lo = 8'd128; hi = 8'd128; end
                5: begin lo = 8'd100; hi = 8'd150; end
                6: begin lo = RESET_LOW; hi = RESET_HIGH; end
                default: begin
                    lo = 8'($urandom_range(0, 127));
                    hi = 8'($urandom_range(128, 255));
                end
            endcase
            write_threshold(CFG_LOW_THRESHOLD, lo);
            write_threshold(CFG_HIGH_THRESHOLD, hi);
            settings_used++;
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) queued_events.push_back(random_item());
            wait_drained();
        end

        if (midi_expected.size() != 0) begin
            $display("%0t: %0d expected packets never arrived", $time, midi_expected.size());
            mismatches += midi_expected.size();
        end
        $display("Ran %0d samples and packets under %0d threshold settings.",
                 items_accepted, settings_used);
        $display("Compared %0d outgoing MIDI packets, %0d field errors.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
